FILE: src/xsd_pkg.sv
// ----------------------------------------------------------------------------
// xsd_pkg
// Shared types and constants for the signed integer divider.
// ----------------------------------------------------------------------------
`default_nettype none

package xsd_pkg;

  localparam int unsigned DW = 64;
  localparam int unsigned NW = 128;

  localparam logic [1:0] MODE_8  = 2'd0;
  localparam logic [1:0] MODE_16 = 2'd1;
  localparam logic [1:0] MODE_32 = 2'd2;
  localparam logic [1:0] MODE_64 = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam int unsigned DEF_BITS_PER_STAGE = 4;

  typedef struct packed {
    logic [1:0]    mode;
    logic          nneg;
    logic          qneg;
    logic          divz;
    logic [DW-1:0] dmag;
  } xsd_ctl_t;

endpackage

`default_nettype wire

FILE: src/xsd_front.sv
// ----------------------------------------------------------------------------
// xsd_front
// Operand alignment: build the signed dividend and divisor, take magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module xsd_front
  import xsd_pkg::*;
(
  input  wire logic [1:0]    mode,
  input  wire logic [DW-1:0] dividend_high,
  input  wire logic [DW-1:0] dividend_low,
  input  wire logic [DW-1:0] divisor,
  output xsd_ctl_t           ctl,
  output logic [NW-1:0]      nmag
);

  logic [NW-1:0] n;
  logic [DW-1:0] dv;
  logic          dneg;

  always_comb begin
    case (mode)
      MODE_8: begin
        n  = {{112{dividend_low[15]}}, dividend_low[15:0]};
        dv = {{56{divisor[7]}}, divisor[7:0]};
      end
      MODE_16: begin
        n  = {{96{dividend_high[15]}}, dividend_high[15:0], dividend_low[15:0]};
        dv = {{48{divisor[15]}}, divisor[15:0]};
      end
      MODE_32: begin
        n  = {{64{dividend_high[31]}}, dividend_high[31:0], dividend_low[31:0]};
        dv = {{32{divisor[31]}}, divisor[31:0]};
      end
      default: begin
        n  = {dividend_high, dividend_low};
        dv = divisor;
      end
    endcase
    dneg     = dv[DW-1];
    ctl.mode = mode;
    ctl.nneg = n[NW-1];
    ctl.qneg = n[NW-1] ^ dneg;
    ctl.divz = (dv == '0);
    ctl.dmag = dneg ? (~dv + DW'(1)) : dv;
    nmag     = n[NW-1] ? (~n + NW'(1)) : n;
  end

endmodule

`default_nettype wire

FILE: src/xsd_stage.sv
// ----------------------------------------------------------------------------
// xsd_stage
// One pipeline stage of restoring long division: several quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module xsd_stage
  import xsd_pkg::*;
#(
  parameter int unsigned BITS = DEF_BITS_PER_STAGE
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          v_in,
  input  xsd_ctl_t           ctl_in,
  input  wire logic [DW-1:0] r_in,
  input  wire logic [NW-1:0] q_in,
  output logic               v_r,
  output xsd_ctl_t           ctl_r,
  output logic [DW-1:0]      r_r,
  output logic [NW-1:0]      q_r
);

  logic [DW-1:0] r_nxt;
  logic [NW-1:0] q_nxt;
  logic [DW:0]   sh;

  always_comb begin
    r_nxt = r_in;
    q_nxt = q_in;
    sh    = '0;
    for (int i = 0; i < BITS; i++) begin
      sh    = {r_nxt, q_nxt[NW-1]};
      q_nxt = {q_nxt[NW-2:0], 1'b0};
      if (sh >= {1'b0, ctl_in.dmag}) begin
        sh       = sh - {1'b0, ctl_in.dmag};
        q_nxt[0] = 1'b1;
      end
      r_nxt = sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r <= ctl_in;
      r_r   <= r_nxt;
      q_r   <= q_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/xsd_back.sv
// ----------------------------------------------------------------------------
// xsd_back
// Result fix-up: range check, sign restore, width mask, status code.
// ----------------------------------------------------------------------------
`default_nettype none

module xsd_back
  import xsd_pkg::*;
(
  input  xsd_ctl_t           ctl,
  input  wire logic [NW-1:0] qmag,
  input  wire logic [DW-1:0] rmag,
  output logic [1:0]         status,
  output logic [DW-1:0]      quotient,
  output logic [DW-1:0]      remainder
);

  logic [DW-1:0] bound, wmask, qs, rs;
  logic          ok;

  always_comb begin
    case (ctl.mode)
      MODE_8:  begin bound = DW'(1) << 7;  wmask = DW'(8'hFF); end
      MODE_16: begin bound = DW'(1) << 15; wmask = DW'(16'hFFFF); end
      MODE_32: begin bound = DW'(1) << 31; wmask = DW'(32'hFFFF_FFFF); end
      default: begin bound = DW'(1) << 63; wmask = '1; end
    endcase
    if (qmag[NW-1:DW] != '0) ok = 1'b0;
    else if (ctl.qneg)       ok = qmag[DW-1:0] <= bound;
    else                     ok = qmag[DW-1:0] < bound;
    qs = ctl.qneg ? (~qmag[DW-1:0] + DW'(1)) : qmag[DW-1:0];
    rs = ctl.nneg ? (~rmag + DW'(1)) : rmag;
    if (ctl.divz) begin
      status = ST_DIVZ; quotient = '0; remainder = '0;
    end else if (!ok) begin
      status = ST_OVF;  quotient = '0; remainder = '0;
    end else begin
      status = ST_OK;   quotient = qs & wmask; remainder = rs & wmask;
    end
  end

endmodule

`default_nettype wire

FILE: src/x86_signed_divider_unit.sv
// ----------------------------------------------------------------------------
// x86_signed_divider_unit
// Pipelined signed divide, 128/64 with x86 width modes and error status.
// ----------------------------------------------------------------------------
// Requests enter on the in_ channel (mode, dividend halves, divisor) and
// results leave on the out_ channel (status, quotient, remainder).
// A request is registered at its accepting edge, then passes through
// 128/BITS_PER_STAGE divide stages and one output register, after which
// its result can leave on the out_ channel.
// Throughput: one request per cycle; the divide stages are a pipeline of
// restoring long-division steps, each retiring BITS_PER_STAGE quotient bits.
// A zero divisor returns status 1, a quotient out of the signed range of the
// width returns status 2, both with zero quotient and remainder.
// Reset clears all valid bits; no request is in flight afterward.
// When the receiver holds out_tready low the whole pipeline holds; a
// stage only advances when the output slot is empty or being taken, so no
// request is lost or repeated. in_tready follows the same advance signal.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_signed_divider_unit
  import xsd_pkg::*;
#(
  parameter int unsigned BITS_PER_STAGE = DEF_BITS_PER_STAGE
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [199:0]   in_tdata,  // mode, dividend_high, dividend_low, divisor
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [135:0]        out_tdata  // status, quotient, remainder, zero pad
);

  localparam int unsigned NST = NW / BITS_PER_STAGE;

  logic          adv;
  xsd_ctl_t      f_ctl;
  logic [NW-1:0] f_n;

  logic          s0_v_r;
  xsd_ctl_t      s0_ctl_r;
  logic [NW-1:0] s0_q_r;

  logic          v_r   [NST+1];
  xsd_ctl_t      ctl_r [NST+1];
  logic [DW-1:0] r_r   [NST+1];
  logic [NW-1:0] q_r   [NST+1];

  logic [1:0]    b_status;
  logic [DW-1:0] b_q, b_r;
  logic          o_v_r;
  logic [129:0]  o_d_r;

  assign adv       = !o_v_r || out_tready;
  assign in_tready = adv;

  xsd_front u_front (
    .mode          (in_tdata[1:0]),
    .dividend_high (in_tdata[65:2]),
    .dividend_low  (in_tdata[129:66]),
    .divisor       (in_tdata[193:130]),
    .ctl           (f_ctl),
    .nmag          (f_n)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ctl_r <= f_ctl;
      s0_q_r   <= f_n;
    end
  end

  assign v_r[0]   = s0_v_r;
  assign ctl_r[0] = s0_ctl_r;
  assign r_r[0]   = '0;
  assign q_r[0]   = s0_q_r;

  for (genvar g = 0; g < NST; g++) begin : g_div
    xsd_stage #(.BITS(BITS_PER_STAGE)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .v_in   (v_r[g]),
      .ctl_in (ctl_r[g]),
      .r_in   (r_r[g]),
      .q_in   (q_r[g]),
      .v_r    (v_r[g+1]),
      .ctl_r  (ctl_r[g+1]),
      .r_r    (r_r[g+1]),
      .q_r    (q_r[g+1])
    );
  end

  xsd_back u_back (
    .ctl       (ctl_r[NST]),
    .qmag      (q_r[NST]),
    .rmag      (r_r[NST]),
    .status    (b_status),
    .quotient  (b_q),
    .remainder (b_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (adv) begin
      o_v_r <= v_r[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_d_r <= {b_r, b_q, b_status};
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {6'd0, o_d_r};

endmodule

`default_nettype wire

FILE: src/xsd_checker.sv
// ----------------------------------------------------------------------------
// xsd_checker
// Port-level checks for the signed divider, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xsd_checker
  import xsd_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [135:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed under stall");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken while output stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[129:2] == '0)
    else $error("error result carries nonzero data");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("bad status code");

endmodule

bind x86_signed_divider_unit xsd_checker u_xsd_checker (.*);

`default_nettype wire

FILE: bench/tb_x86_signed_divider_unit.sv
// ----------------------------------------------------------------------------
// tb_x86_signed_divider_unit
// Self-checking bench for the pipelined x86 signed divider.
// ----------------------------------------------------------------------------
// Sends divide requests on in_ with random gaps and checks every result on out_
// against a local 128/64 signed divide predictor with status codes. Covers
// each width, zero divisors, quotient overflow, ignored upper bits, a long
// receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_x86_signed_divider_unit;
  import xsd_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [199:0] in_tdata;  // mode[1:0], dividend_high[65:2], dividend_low[129:66], divisor[193:130]
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata; // status[1:0], quotient[65:2], remainder[129:66]

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] quot;
    logic [1:0]  status;
  } div_result_t;

  div_result_t pending_results[$];
  int          errors;
  int          hold_cycles;
  bit          hold_idle;

  x86_signed_divider_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb_x86_signed_divider_unit failed");
    $finish;
  end

  function automatic div_result_t idiv_predict(logic [1:0] mode, logic [63:0] dh,
                                               logic [63:0] dl, logic [63:0] dvs);
    div_result_t     res;
    int              w;
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic [127:0]    nmag;
    logic [127:0]    dmag;
    logic [127:0]    qmag;
    logic [127:0]    rmag;
    logic [127:0]    bound;
    logic [63:0]     wmask;
    logic            qneg;
    w = 8 << mode;
    wmask = (w == 64) ? '1 : ((64'd1 << w) - 1);
    res = '0;
    case (mode)
      MODE_8:  num = {{112{dl[15]}}, dl[15:0]};
      MODE_16: num = {{96{dh[15]}}, dh[15:0], dl[15:0]};
      MODE_32: num = {{64{dh[31]}}, dh[31:0], dl[31:0]};
      default: num = {dh, dl};
    endcase
    den = $signed({64'd0, dvs & wmask}) <<< (128 - w) >>> (128 - w);
    if (den == 0) begin
      res.status = ST_DIVZ;
      return res;
    end
    nmag = num[127] ? -num : num;
    dmag = den[127] ? -den : den;
    qmag = nmag / dmag;
    rmag = nmag % dmag;
    qneg = num[127] ^ den[127];
    bound = 128'd1 << (w - 1);
    if (qneg ? (qmag > bound) : (qmag >= bound)) begin
      res.status = ST_OVF;
      return res;
    end
    res.status = ST_OK;
    res.quot = (qneg ? -qmag[63:0] : qmag[63:0]) & wmask;
    res.rem = (num[127] ? -rmag[63:0] : rmag[63:0]) & wmask;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic send_divide(logic [1:0] mode, logic [63:0] dh, logic [63:0] dl,
                             logic [63:0] dvs, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, dvs, dl, dh, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(idiv_predict(mode, dh, dl, dvs));
    @(negedge clk);
  endtask

  // receiver: random stalls, or a long hold while hold_cycles is set
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      stall = hold_idle ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18));
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  initial begin
    div_result_t got;
    div_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = out_tdata[129:0];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", got.quot, 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            report_mismatch("status", 64'(got.status), 64'(want.status));
          end
          if (got.quot !== want.quot) report_mismatch("quotient", got.quot, want.quot);
          if (got.rem !== want.rem) report_mismatch("remainder", got.rem, want.rem);
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    logic [1:0] m;
    for (int i = 0; i < 4; i++) begin
      m = i[1:0];
      send_divide(m, 64'd0, 64'd100, 64'd7);
      send_divide(m, '1, -64'd100, 64'd7);
      send_divide(m, rand64(), rand64(), 64'hFFFF_FFFF_FFFF_FF00 << (8 << m));
      send_divide(m, 64'd0, 64'd1 << ((8 << m) - 1), -64'd1);
    end
    send_divide(MODE_8, '1, 64'h8000, -64'd1);
    send_divide(MODE_16, 64'h8000, 64'd0, -64'd1);
    send_divide(MODE_32, 64'h8000_0000, 64'd0, -64'd1);
    send_divide(MODE_64, 64'h8000_0000_0000_0000, 64'd0, -64'd1);
    send_divide(MODE_64, 64'h7FFF_FFFF_FFFF_FFFF, '1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_divide(MODE_64, 64'hC000_0000_0000_0000, 64'd0, 64'h8000_0000_0000_0000);
    send_divide(MODE_8, 64'd0, 64'hFFFF_FFFF_FFFF_7F80, 64'hFFFF_FFFF_FFFF_FF80);
    send_divide(MODE_32, '1, '1, '1);
    send_divide(MODE_64, '1, '1, '1);
  endtask

  task automatic test_random(int count);
    logic [1:0]  m;
    logic [63:0] dvs;
    logic [63:0] dh;
    int          w;
    for (int i = 0; i < count; i++) begin
      m = 2'($urandom_range(0, 3));
      w = 8 << m;
      dvs = rand64();
      if ($urandom_range(0, 3) == 0) dvs = dvs >> $urandom_range(0, 63);
      if ($urandom_range(0, 20) == 0) dvs = dvs & ~((w == 64) ? '1 : ((64'd1 << w) - 1));
      dh = rand64();
      // mostly keep the upper half small so many quotients fit the width
      if ($urandom_range(0, 2) != 0) begin
        dh = dh >> $urandom_range(w / 2, 64);
        if ($urandom_range(0, 1) == 1) dh = ~dh;
      end
      send_divide(m, dh, rand64(), dvs);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    hold_idle = 1;
    for (int i = 0; i < 60; i++) send_divide(2'($urandom_range(0, 3)), rand64() >> 40,
                                              rand64(), rand64(), 1);
    hold_idle = 0;
  endtask

  task automatic test_drain_pause();
    test_random(20);
    wait_drained();
    test_random(20);
  endtask

  initial begin
    errors = 0;
    hold_cycles = 0;
    hold_idle = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random(430);
    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_x86_signed_divider_unit passed");
    end else begin
      $display("tb_x86_signed_divider_unit failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
